// ----- sv/color_gradient_edge_magnitude_core_assert.svh -----
// Assertion macros shared by the edge magnitude core modules.
`ifndef COLOR_GRADIENT_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define COLOR_GRADIENT_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// Invariant that must hold at every clock edge outside reset.
`define CGEM_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define CGEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/cgem_pkg.sv -----
// Shared types, constants and arithmetic helpers of the edge magnitude core.
`timescale 1ns / 1ps
package cgem_pkg;

  localparam int CH_W  = 8;
  localparam int NCH   = 3;
  localparam int PIX_W = CH_W * NCH;
  localparam int CFG_W = 12;
  localparam int SQ_W  = 17;   // dx^2 + dy^2 and the three-channel sum
  localparam int QT_W  = 16;   // one channel after the divide by three

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SH, exact for x < 2^19
  localparam logic [17:0] DIV3_MUL = 18'd174763;
  localparam int          DIV3_SH  = 19;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [NCH-1:0][CH_W-1:0] dx;
    logic [NCH-1:0][CH_W-1:0] dy;
  } diff_t;

  typedef struct packed {
    logic pix_valid;
    logic last;
  } meta_t;

  typedef struct packed {
    diff_t d;
    meta_t m;
  } qent_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sqs_t;

  // One step of the digit-by-digit square root, trial bit 4^k
  function automatic sqs_t sqrt_step(input sqs_t s, input int unsigned k);
    logic [SQ_W:0]   t;
    logic [SQ_W-1:0] b;
    sqs_t            o;
    b = SQ_W'(1) << (2 * k);
    t = {1'b0, s.res} + {1'b0, b};
    o = s;
    if ({1'b0, s.v} >= t) begin
      o.v   = s.v - t[SQ_W-1:0];
      o.res = (s.res >> 1) + b;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic logic [CH_W-1:0] pos_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

// ----- sv/cgem_fifo.sv -----
// Short queue that decouples pixel intake from the arithmetic pipeline.
`timescale 1ns / 1ps
`include "color_gradient_edge_magnitude_core_assert.svh"
module cgem_fifo import cgem_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output qent_t pop_ent,
  output logic  not_empty
);

  qent_t             ent_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_ent   = ent_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  `CGEM_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `CGEM_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, not_empty, "pop from empty queue")

endmodule

// ----- sv/cgem_front.sv -----
// Front end: frame position, two line memories, 3x3 neighborhood taps, classification.
`timescale 1ns / 1ps
`include "color_gradient_edge_magnitude_core_assert.svh"
module cgem_front import cgem_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,
  input  logic             q_full,
  output logic             push,
  output qent_t            push_ent
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int XW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam logic [XW-1:0]    MAXW_X  = XW'(MAX_WIDTH);
  localparam logic [CW-1:0]    RST_WM1 = CW'(RST_W - 1);
  localparam logic [CFG_W-1:0] RST_HM1 = CFG_W'(479);

  logic [CW-1:0]    w_m1_r, w_m1_nxt;
  logic [CFG_W-1:0] h_m1_r, h_m1_nxt;
  logic [CW-1:0]    col_r, col_nxt, col_adv;
  logic [CFG_W-1:0] row_r, row_nxt, row_adv;
  logic [PIX_W-1:0] win_r [4];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_newer_r, rd_older_r;
  logic [CW-1:0]    rd_addr;
  logic [XW-1:0]    w_x, w_clamp;
  logic [CFG_W-1:0] h_clamp;
  logic             accept, col_wrap, interior;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept;
  assign col_wrap  = (col_r == w_m1_r);

  // saturate written geometry into its legal range, keep size minus one
  always_comb begin
    w_x     = XW'(cfg_wdata);
    w_clamp = w_x;
    if (w_x < XW'(3)) begin
      w_clamp = XW'(3);
    end else if (w_x > MAXW_X) begin
      w_clamp = MAXW_X;
    end
    h_clamp  = (cfg_wdata < CFG_W'(3)) ? CFG_W'(3) : cfg_wdata;
    w_m1_nxt = w_m1_r;
    h_m1_nxt = h_m1_r;
    if (cfg_we && cfg_addr == CFG_IMAGE_WIDTH) begin
      w_m1_nxt = CW'(w_clamp - XW'(1));
    end
    if (cfg_we && cfg_addr == CFG_IMAGE_HEIGHT) begin
      h_m1_nxt = h_clamp - CFG_W'(1);
    end
  end

  // raster position of the next pixel; any register write restarts the frame
  always_comb begin
    col_adv = col_wrap ? '0 : col_r + 1'b1;
    row_adv = row_r;
    if (col_wrap) begin
      row_adv = (row_r == h_m1_r) ? '0 : row_r + 1'b1;
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      col_nxt = col_adv;
      row_nxt = row_adv;
    end
  end

  // line memories read one column ahead so data is ready at the next transfer
  always_comb begin
    rd_addr = col_r;
    if (!rst_n || cfg_we) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= RST_WM1;
      h_m1_r <= RST_HM1;
      col_r  <= '0;
      row_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      w_m1_r <= w_m1_nxt;
      h_m1_r <= h_m1_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      if (accept) begin
        win_r[1] <= win_r[0];
        win_r[0] <= rd_newer_r;
        win_r[2] <= rd_older_r;
        win_r[3] <= in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      older_mem[col_r] <= rd_newer_r;
      newer_mem[col_r] <= in_tdata;
    end
    rd_newer_r <= newer_mem[rd_addr];
    rd_older_r <= older_mem[rd_addr];
  end

  // classify the output position and form clipped central differences
  assign interior = (row_r >= CFG_W'(2)) && (col_r >= CW'(2));

  always_comb begin
    push_ent.m.pix_valid = (row_r >= CFG_W'(2)) ||
                           ((row_r == CFG_W'(1)) && (col_r != '0));
    push_ent.m.last      = (row_r == h_m1_r) && col_wrap;
    for (int k = 0; k < NCH; k++) begin
      push_ent.d.dx[k] = '0;
      push_ent.d.dy[k] = '0;
      if (interior) begin
        push_ent.d.dx[k] = pos_diff(rd_newer_r[CH_W*k +: CH_W], win_r[1][CH_W*k +: CH_W]);
        push_ent.d.dy[k] = pos_diff(win_r[3][CH_W*k +: CH_W], win_r[2][CH_W*k +: CH_W]);
      end
    end
  end

  `CGEM_ASSERT(a_col_in_frame, clk, rst_n, col_r <= w_m1_r, "column past row end")
  `CGEM_ASSERT(a_row_in_frame, clk, rst_n, row_r <= h_m1_r, "row past frame end")

endmodule

// ----- sv/cgem_back.sv -----
// Back end: squares, divide by three, channel sum, pipelined square root, output register.
`timescale 1ns / 1ps
`include "color_gradient_edge_magnitude_core_assert.svh"
module cgem_back import cgem_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  qent_t           q_ent,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [CH_W-1:0] out_tdata,   // [7:0] edge_value
  output logic            out_tuser,   // [0] out_valid
  output logic            out_tlast
);

  logic                adv, pop;
  logic [5:0]          vld_r;
  meta_t               meta_r [6];
  logic [SQ_W-1:0]     sq_r [NCH];
  logic [QT_W-1:0]     qt_r [NCH];
  logic [SQ_W-1:0]     sum_r;
  sqs_t                rt_a_r, rt_b_r, rt_c_r;
  sqs_t                rt_init;
  logic [SQ_W+17:0]    prod [NCH];
  logic                out_vld_r;
  meta_t               out_meta_r;
  logic [CH_W-1:0]     edge_r;

  // the whole pipe moves whenever the output slot is free or being drained
  assign adv     = !out_vld_r || out_tready;
  assign q_ready = adv;
  assign pop     = q_valid && adv;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = edge_r;
  assign out_tuser  = out_meta_r.pix_valid;
  assign out_tlast  = out_meta_r.last;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      prod[k] = (SQ_W+18)'(sq_r[k]) * (SQ_W+18)'(DIV3_MUL);
    end
    rt_init.v   = sum_r;
    rt_init.res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[4:0], pop};
      out_vld_r <= vld_r[5];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= q_ent.m;
      for (int s = 1; s < 6; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
      out_meta_r <= meta_r[5];
      for (int k = 0; k < NCH; k++) begin
        sq_r[k] <= SQ_W'(q_ent.d.dx[k]) * SQ_W'(q_ent.d.dx[k]) +
                   SQ_W'(q_ent.d.dy[k]) * SQ_W'(q_ent.d.dy[k]);
        qt_r[k] <= prod[k][DIV3_SH +: QT_W];
      end
      sum_r  <= SQ_W'(qt_r[0]) + SQ_W'(qt_r[1]) + SQ_W'(qt_r[2]);
      rt_a_r <= sqrt_step(sqrt_step(sqrt_step(rt_init, 8), 7), 6);
      rt_b_r <= sqrt_step(sqrt_step(sqrt_step(rt_a_r, 5), 4), 3);
      rt_c_r <= sqrt_step(sqrt_step(sqrt_step(rt_b_r, 2), 1), 0);
      edge_r <= (rt_c_r.res > SQ_W'(255)) ? {CH_W{1'b1}} : rt_c_r.res[CH_W-1:0];
    end
  end

  `CGEM_ASSERT_IMP(a_last_on_pixel, clk, rst_n, out_vld_r && out_meta_r.last,
                   out_meta_r.pix_valid, "frame end flagged on a non-pixel result")

endmodule

// ----- sv/color_gradient_edge_magnitude_core.sv -----
// Throughput: one pixel per clock until the 4-entry queue fills behind a stalled output.
// Each result belongs to the pixel image_width+1 transfers earlier; registered line RAM reads.
// Reset (rst_n low, synchronous): frame position, queue and pipeline valids cleared,
// geometry back to 640 x 480; line memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module color_gradient_edge_magnitude_core import cgem_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,    // [7:0] chan_zero, [15:8] chan_one, [23:16] chan_two
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [CH_W-1:0]  out_tdata,   // [7:0] edge_value
  output logic             out_tuser,   // [0] out_valid
  output logic             out_tlast
);

  logic  q_full, q_push, q_not_empty, q_ready, q_pop;
  qent_t q_in, q_out;

  assign q_pop = q_not_empty && q_ready;

  cgem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (q_push),
    .push_ent  (q_in)
  );

  cgem_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ent  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_ent   (q_out),
    .not_empty (q_not_empty)
  );

  cgem_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_ready    (q_ready),
    .q_ent      (q_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the streaming color gradient edge magnitude core.
`timescale 1ns / 1ps
module tb import cgem_pkg::*;;

  localparam int FRAME_MAX_W = 2048;
  localparam int FRAME_MAX_H = 4095;
  localparam int RANDOM_ITEMS = 1200;
  localparam int WIDE_ITEMS = 300;

  typedef struct packed {
    logic [CH_W-1:0] edge_val;
    logic            pix_valid;
    logic            last_flag;
  } edge_result_t;

  typedef enum logic {STEP_PIXEL, STEP_GEOMETRY} step_kind_t;

  // One directed step: a pixel, or a geometry write with {height, width} in data
  typedef struct packed {
    step_kind_t       kind;
    logic [PIX_W-1:0] data;
    logic             typed;
    edge_result_t     want;
  } step_row_t;

  typedef enum logic [1:0] {TONE_NOISE, TONE_RAILS, TONE_RAMP, TONE_PATCH} tone_t;

  localparam edge_result_t NO_PIX  = '{8'd0, 1'b0, 1'b0};
  localparam edge_result_t BORDER  = '{8'd0, 1'b1, 1'b0};

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_addr   = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [CH_W-1:0]  out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  // Typed expectation riding along with the pixel currently on the bus
  logic             row_typed  = 1'b0;
  edge_result_t     row_expect = NO_PIX;

  // Predictor state
  logic [CFG_W-1:0] geo_width_raw;
  logic [CFG_W-1:0] geo_height_raw;
  logic [PIX_W-1:0] upper_line [FRAME_MAX_W];
  logic [PIX_W-1:0] lower_line [FRAME_MAX_W];
  logic [PIX_W-1:0] win_reg [4];
  int unsigned      next_col;
  int unsigned      next_row;

  edge_result_t     expected_edges [$];
  int               items_sent   = 0;
  int               results_seen = 0;
  int               error_count  = 0;
  bit               steady_in    = 1'b0;
  bit               steady_out   = 1'b0;
  int unsigned      stall_left   = 0;

  step_row_t        directed_rows [23];

  color_gradient_edge_magnitude_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_fault(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Geometry value actually in use after saturation
  function automatic int unsigned used_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned acc;
    int unsigned trial;
    acc = 0;
    for (int b = 9; b >= 0; b--) begin
      trial = acc + (1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic int unsigned rise(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    return (a > b) ? a - b : 0;
  endfunction

  // Mirror of the block for one accepted pixel
  task automatic step_predictor(input logic [PIX_W-1:0] px, output edge_result_t res);
    int unsigned w, h, c, r, orow, ocol, sum, dx, dy, root;
    logic [PIX_W-1:0] right_px, older_px, left_px, above_px, below_px;
    w = used_dim(geo_width_raw, FRAME_MAX_W);
    h = used_dim(geo_height_raw, FRAME_MAX_H);
    c = (next_col >= w) ? w - 1 : next_col;
    r = (next_row >= h) ? h - 1 : next_row;
    right_px = lower_line[c];
    older_px = upper_line[c];
    left_px  = win_reg[1];
    above_px = win_reg[2];
    below_px = win_reg[3];
    res = NO_PIX;
    if (r >= 2 || (r == 1 && c >= 1)) begin
      orow = (c >= 1) ? r - 1 : r - 2;
      ocol = (c >= 1) ? c - 1 : w - 1;
      res.pix_valid = 1'b1;
      // interior pixels only; the frame border stays zero
      if (orow != 0 && orow < h - 1 && ocol != 0 && ocol < w - 1) begin
        sum = 0;
        for (int k = 0; k < NCH; k++) begin
          dx = rise(right_px[8*k +: 8], left_px[8*k +: 8]);
          dy = rise(below_px[8*k +: 8], above_px[8*k +: 8]);
          sum += (dx * dx + dy * dy) / 3;
        end
        root = floor_root(sum);
        res.edge_val = (root > 255) ? 8'd255 : root[7:0];
      end
      res.last_flag = (r == h - 1 && c == w - 1);
    end
    win_reg[1] = win_reg[0];
    win_reg[0] = right_px;
    win_reg[2] = older_px;
    win_reg[3] = px;
    upper_line[c] = right_px;
    lower_line[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(input tone_t tone, input logic [PIX_W-1:0] base);
    logic [PIX_W-1:0] px;
    int v;
    px = PIX_W'($urandom);
    for (int k = 0; k < NCH; k++) begin
      case (tone)
        TONE_RAILS: begin
          px[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        TONE_RAMP: begin
          v = int'(base[8*k +: 8]) + int'($urandom_range(0, 8)) - 4;
          px[8*k +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
        end
        TONE_PATCH: begin
          if ($urandom_range(0, 3) != 0) px[8*k +: 8] = base[8*k +: 8];
        end
        default: ;
      endcase
    end
    return px;
  endfunction

  // Pixel transfer with optional idle cycles ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed,
                            input edge_result_t want);
    int unsigned gap;
    gap = steady_in ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= px;
    row_typed  <= typed;
    row_expect <= want;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Wait until every pixel sent has produced its result
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  task automatic write_geometry(input bit do_w, input bit do_h,
                                input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_IMAGE_WIDTH;
      cfg_wdata <= w;
      @(posedge clk);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_IMAGE_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Predictor, scoreboard and result-side ready pattern
  always @(posedge clk) begin : monitor
    edge_result_t guess;
    edge_result_t want;
    int unsigned  n;
    if (!rst_n) begin
      geo_width_raw  = 12'd640;
      geo_height_raw = 12'd480;
      for (int i = 0; i < FRAME_MAX_W; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      for (int i = 0; i < 4; i++) win_reg[i] = '0;
      next_col = 0;
      next_row = 0;
      out_tready <= 1'b0;
    end else begin
      // a register write restarts the frame
      if (cfg_we) begin
        if (cfg_addr == CFG_IMAGE_WIDTH) geo_width_raw = cfg_wdata;
        else geo_height_raw = cfg_wdata;
        next_col = 0;
        next_row = 0;
      end
      if (in_tvalid && in_tready) begin
        step_predictor(in_tdata, guess);
        expected_edges.push_back(row_typed ? row_expect : guess);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_edges.size() == 0) begin
          flag_fault($sformatf("unexpected result edge=%0d valid=%b last=%b",
                               out_tdata, out_tuser, out_tlast));
        end else begin
          want = expected_edges.pop_front();
          if (out_tdata !== want.edge_val || out_tuser !== want.pix_valid ||
              out_tlast !== want.last_flag)
            flag_fault($sformatf("result %0d: got %0d/%b/%b, want %0d/%b/%b",
                                 results_seen, out_tdata, out_tuser, out_tlast,
                                 want.edge_val, want.pix_valid, want.last_flag));
        end
      end
      // back-pressure: random stalls with calm stretches
      if ($urandom_range(0, 499) == 0) steady_out = !steady_out;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (steady_out) begin
        out_tready <= 1'b1;
      end else begin
        n = idle_len();
        if (n == 0) begin
          out_tready <= 1'b1;
        end else begin
          stall_left = n - 1;
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [CFG_W-1:0] cur_w, cur_h, new_w, new_h;
    logic [PIX_W-1:0] base;
    tone_t            tone;
    int unsigned      pick, n, w_eff, h_eff;
    int               random_items;
    // after reset, then two 3x3 frames: saturation and negative differences
    directed_rows = '{
      '{STEP_PIXEL, 24'h000000, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'hFFFFFF, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h00FF00, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'hA5A5A5, 1'b1, NO_PIX},
      '{STEP_GEOMETRY, 24'h003003, 1'b0, NO_PIX},
      '{STEP_PIXEL, 24'h123456, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h000000, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h808080, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h000000, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h7F7F7F, 1'b1, BORDER},
      '{STEP_PIXEL, 24'hFFFFFF, 1'b1, BORDER},
      '{STEP_PIXEL, 24'h55AA55, 1'b1, BORDER},
      '{STEP_PIXEL, 24'hFFFFFF, 1'b1, BORDER},
      '{STEP_PIXEL, 24'h010203, 1'b1, '{8'd255, 1'b1, 1'b1}},
      '{STEP_PIXEL, 24'h3C3C3C, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'hFFFFFF, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h000000, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'hFFFFFF, 1'b1, NO_PIX},
      '{STEP_PIXEL, 24'h808080, 1'b1, BORDER},
      '{STEP_PIXEL, 24'h000000, 1'b1, BORDER},
      '{STEP_PIXEL, 24'hC0FFEE, 1'b1, BORDER},
      '{STEP_PIXEL, 24'h000000, 1'b1, BORDER},
      '{STEP_PIXEL, 24'hFF00FF, 1'b1, '{8'd0, 1'b1, 1'b1}}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STEP_GEOMETRY) begin
        settle();
        write_geometry(1'b1, 1'b1, directed_rows[i].data[11:0], directed_rows[i].data[23:12]);
      end else begin
        send_pixel(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // widest rows: the width saturates to the maximum; the pixels sent stay within the first row
    settle();
    write_geometry(1'b1, 1'b1, 12'd4095, 12'd3);
    cur_w = 12'd4095;
    cur_h = 12'd3;
    steady_in = ($urandom_range(0, 1) == 0);
    repeat (WIDE_ITEMS) send_pixel(PIX_W'($urandom), 1'b0, NO_PIX);

    // random phases, mostly small frames
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 99);
      new_w = CFG_W'($urandom_range(3, 12));
      if (pick % 25 < 2) new_w = CFG_W'($urandom_range(0, 2));
      else if (pick % 25 < 4) new_w = CFG_W'($urandom_range(13, 64));
      new_h = CFG_W'($urandom_range(3, 8));
      pick = $urandom_range(0, 99);
      if (pick < 8) new_h = CFG_W'($urandom_range(0, 2));
      else if (pick < 16) new_h = CFG_W'($urandom_range(9, 20));
      else if (pick < 20) new_h = 12'd4095;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        write_geometry(1'b1, 1'b1, new_w, new_h);
        cur_w = new_w;
        cur_h = new_h;
      end else if (pick < 80) begin
        write_geometry(1'b1, 1'b0, new_w, new_h);
        cur_w = new_w;
      end else if (pick < 90) begin
        write_geometry(1'b0, 1'b1, new_w, new_h);
        cur_h = new_h;
      end
      w_eff = used_dim(cur_w, FRAME_MAX_W);
      h_eff = used_dim(cur_h, FRAME_MAX_H);
      // keep the max-width geometry from flooding the random part
      if (w_eff > 64) begin
        write_geometry(1'b1, 1'b0, new_w, new_h);
        cur_w = new_w;
        w_eff = used_dim(cur_w, FRAME_MAX_W);
      end
      if (h_eff <= 20 && $urandom_range(0, 3) != 0)
        n = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
      else
        n = $urandom_range(1, 4 * w_eff);
      steady_in = ($urandom_range(0, 3) == 0);
      tone = tone_t'($urandom_range(0, 3));
      base = PIX_W'($urandom);
      repeat (n) begin
        base = make_pixel(tone, base);
        send_pixel(base, 1'b0, NO_PIX);
        random_items++;
      end
    end

    // drain, then give stray results time to show up
    settle();
    repeat (20) @(posedge clk);
    if (expected_edges.size() != 0)
      flag_fault($sformatf("%0d results never arrived", expected_edges.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
